// ----- design/rdvp_pkg.sv -----
package rdvp_pkg;

    // parser phase codes
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_TAG   = 2'd1;
    localparam logic [1:0] PHASE_VALUE = 2'd2;

    // message type of a riding message (first byte)
    localparam logic [7:0] MSG_RIDING = 8'h03;

    // field tags
    localparam logic [7:0] TAG_POWER   = 8'h08;
    localparam logic [7:0] TAG_CADENCE = 8'h10;
    localparam logic [7:0] TAG_SPEED   = 8'h18;
    localparam logic [7:0] TAG_HEART   = 8'h20;
    localparam logic [7:0] TAG_VALID   = 8'h30;

    // varint group handling
    localparam int unsigned VAL_W       = 32;
    localparam int unsigned SHIFT_W     = 6;
    localparam int unsigned GROUP_W     = 7;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0] power_watts;
        logic [VAL_W-1:0] cadence_rpm;
        logic [VAL_W-1:0] speed_hundredths;
        logic [VAL_W-1:0] heart_bpm;
        logic             record_valid;
    } t_out_word;

endpackage

// ----- design/riding_data_varint_parser_unit.sv -----
// Riding-data varint parser.
// Input channel (i_in_valid / o_in_ready / i_in_word) carries one message byte
// per word, with first_byte and last_byte marks. A message whose first byte is
// 0x03 is parsed as tag / varint pairs that update power, cadence, speed
// (integer hundredths) and heart rate; tag 0x30 sets the record valid flag.
// On the last byte of such a message one word with the stored record leaves
// on the output channel (o_out_valid / i_out_ready / o_out_word). All other
// messages give no output word.
// Pipeline: an accepted byte is held in the input register, and the parse step
// runs between that register and the output register, which holds the record.
// Throughput: one byte per cycle unless the input stage waits (see below).
// The parse step for a byte is a single pass of shift-or logic and tag decode.
// When the receiver stalls, the output word holds; bytes that do not close a
// riding message keep flowing, and the input stage only waits when its byte
// would produce a record while the previous record is still untaken.
// Reset (synchronous, active low) returns the parser to idle and clears the
// stored record and the valid flags of both pipeline registers.
module riding_data_varint_parser_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rdvp_pkg::t_in_word  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rdvp_pkg::t_out_word o_out_word
);

    localparam int unsigned VW = rdvp_pkg::VAL_W;
    localparam int unsigned SW = rdvp_pkg::SHIFT_W;
    localparam int unsigned GW = rdvp_pkg::GROUP_W;

    // input stage
    logic               r_in_valid;
    rdvp_pkg::t_in_word r_in_word;

    // parser state
    logic [1:0]    r_phase,   n_phase;
    logic [7:0]    r_tag,     n_tag;
    logic [VW-1:0] r_accum,   n_accum;
    logic [SW-1:0] r_shift,   n_shift;
    logic [VW-1:0] r_power,   n_power;
    logic [VW-1:0] r_cadence, n_cadence;
    logic [VW-1:0] r_speed,   n_speed;
    logic [VW-1:0] r_heart,   n_heart;
    logic          r_flag,    n_flag;

    // output stage
    logic                r_out_valid;
    rdvp_pkg::t_out_word r_out_word;

    logic          emit;
    logic          advance;
    logic          do_apply;
    logic [7:0]    apply_tag;
    logic [VW-1:0] apply_val;
    logic [VW-1:0] group_val;

    // input stage moves on unless its record would overwrite an untaken one
    assign advance    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // next group of the varint placed at its bit position
    assign group_val = VW'(r_in_word.byte_in[GW-1:0]) << r_shift;

    // parse step for the byte in the input register
    always_comb begin
        n_phase   = r_phase;
        n_tag     = r_tag;
        n_accum   = r_accum;
        n_shift   = r_shift;
        n_flag    = r_flag;
        emit      = 1'b0;
        do_apply  = 1'b0;
        apply_tag = r_tag;
        apply_val = '0;

        if (r_in_word.first_byte) begin
            if (r_in_word.byte_in == rdvp_pkg::MSG_RIDING) begin
                n_flag  = 1'b0;
                n_tag   = '0;
                n_accum = '0;
                n_shift = '0;
                if (r_in_word.last_byte) begin
                    n_phase = rdvp_pkg::PHASE_IDLE;
                    emit    = 1'b1;
                end else begin
                    n_phase = rdvp_pkg::PHASE_TAG;
                end
            end else begin
                n_phase = rdvp_pkg::PHASE_IDLE;
            end
        end else begin
            case (r_phase)
                rdvp_pkg::PHASE_TAG: begin
                    n_tag     = r_in_word.byte_in;
                    n_accum   = '0;
                    n_shift   = '0;
                    apply_tag = r_in_word.byte_in;
                    if (r_in_word.last_byte) begin
                        // tag with no value bytes applies zero
                        do_apply = 1'b1;
                        n_phase  = rdvp_pkg::PHASE_IDLE;
                        emit     = 1'b1;
                    end else begin
                        n_phase = rdvp_pkg::PHASE_VALUE;
                    end
                end
                rdvp_pkg::PHASE_VALUE: begin
                    // groups at or past bit 32 are dropped
                    if (!r_shift[SW-1]) begin
                        n_accum = r_accum | group_val;
                        n_shift = r_shift + SW'(GW);
                    end
                    apply_val = n_accum;
                    if (!r_in_word.byte_in[7] || r_in_word.last_byte) begin
                        do_apply = 1'b1;
                        if (r_in_word.last_byte) begin
                            n_phase = rdvp_pkg::PHASE_IDLE;
                            emit    = 1'b1;
                        end else begin
                            n_phase = rdvp_pkg::PHASE_TAG;
                        end
                    end
                end
                default: begin
                    n_phase = rdvp_pkg::PHASE_IDLE;
                end
            endcase
        end

        // field dispatch
        n_power   = r_power;
        n_cadence = r_cadence;
        n_speed   = r_speed;
        n_heart   = r_heart;
        if (do_apply) begin
            case (apply_tag)
                rdvp_pkg::TAG_POWER:   n_power   = apply_val;
                rdvp_pkg::TAG_CADENCE: n_cadence = apply_val;
                rdvp_pkg::TAG_SPEED:   n_speed   = apply_val;
                rdvp_pkg::TAG_HEART:   n_heart   = apply_val;
                rdvp_pkg::TAG_VALID:   n_flag    = 1'b1;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // parser state and stored record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rdvp_pkg::PHASE_IDLE;
            r_tag     <= '0;
            r_accum   <= '0;
            r_shift   <= '0;
            r_power   <= '0;
            r_cadence <= '0;
            r_speed   <= '0;
            r_heart   <= '0;
            r_flag    <= 1'b0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_tag     <= n_tag;
            r_accum   <= n_accum;
            r_shift   <= n_shift;
            r_power   <= n_power;
            r_cadence <= n_cadence;
            r_speed   <= n_speed;
            r_heart   <= n_heart;
            r_flag    <= n_flag;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_out_word.power_watts      <= n_power;
            r_out_word.cadence_rpm      <= n_cadence;
            r_out_word.speed_hundredths <= n_speed;
            r_out_word.heart_bpm        <= n_heart;
            r_out_word.record_valid     <= n_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- design/rdvp_checker.sv -----
module rdvp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input rdvp_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rdvp_pkg::t_out_word o_out_word
);

    // stalled record word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // a fresh record traces back to an accepted last byte
    a_rec_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && i_in_word.last_byte, 2))
        else $error("record without a closing byte");

    // input side never waits while the output is empty
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind riding_data_varint_parser_unit rdvp_checker u_rdvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
